// File: hdl/daesm_pkg.sv
`timescale 1ns / 1ps

package daesm_pkg;

	// Field and datapath widths
	localparam int SAMPLE_W   = 12;
	localparam int FRAC_W     = 16;
	localparam int BASE_W     = 29;
	localparam int WHOLE_W    = 13;
	localparam int SQ_W       = 25;
	localparam int SUM_W      = 30;
	localparam int TOL_W      = 28;
	localparam int RUN_W      = 10;
	localparam int OFFS_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// Ring depth default
	localparam int WINDOW_DEF = 53;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOL_OFFSET = 2'd1;
	localparam logic [RUN_W-1:0]     RUN_TARGET_RST = 10'd71;
	localparam logic [OFFS_W-1:0]    TOL_OFFSET_RST = 8'd5;

	// x/25 = (x * RECIP_25) >> 30, exact for x < 2^30 (x/200 = (x/8)/25)
	localparam int               RECIP_25_SH = 30;
	localparam logic [25:0]      RECIP_25    = 26'd42949673;
	// x/10 = (x * RECIP_10) >> 33, exact for x < 2^30
	localparam int               RECIP_10_SH = 33;
	localparam logic [29:0]      RECIP_10    = 30'd858993460;

	// Stage advance strobes from the pipeline control
	typedef struct packed {
		logic take;     // input beat accepted into s1
		logic adv2;     // s1 -> s2, ring read issued
		logic adv3;     // s2 -> s3, ring write and sum update
		logic adv4;     // s3 -> s4
		logic adv_out;  // s4 -> output register
	} daesm_ctl_t;

endpackage

// File: hdl/daesm_if.sv
`timescale 1ns / 1ps

// Sample pair channel
interface daesm_smp_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [daesm_pkg::SAMPLE_W-1:0]    sample_a;
	logic signed [daesm_pkg::SAMPLE_W-1:0]    sample_b;
	modport source (output valid, sample_a, sample_b, input ready);
	modport sink (input valid, sample_a, sample_b, output ready);
endinterface

// Result channel
interface daesm_res_if;
	logic                               valid;
	logic                               ready;
	logic [daesm_pkg::SUM_W-1:0]        energy_a;
	logic [daesm_pkg::SUM_W-1:0]        energy_b;
	logic                               stable;
	modport source (output valid, energy_a, energy_b, stable, input ready);
	modport sink (input valid, energy_a, energy_b, stable, output ready);
endinterface

// Register write channel
interface daesm_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [daesm_pkg::CFG_IDX_W-1:0]       index;
	logic [daesm_pkg::CFG_DATA_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/daesm_chan.sv
`timescale 1ns / 1ps

// One channel: DC baseline, squared residual ring, window sum, steadiness test.
module daesm_chan #(
	parameter int  WINDOW = daesm_pkg::WINDOW_DEF,
	localparam int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  daesm_pkg::daesm_ctl_t                 ctl,
	input  logic signed [daesm_pkg::SAMPLE_W-1:0] sample,
	input  logic [AW-1:0]                         rd_addr,
	input  logic [AW-1:0]                         wr_addr,
	input  logic [daesm_pkg::OFFS_W-1:0]          tol_offset,
	output logic [daesm_pkg::SUM_W-1:0]           sum,
	output logic                                  steady
);

	localparam int BW = daesm_pkg::BASE_W;
	localparam int SW = daesm_pkg::SUM_W;
	localparam int QW = daesm_pkg::SQ_W;

	// State registers
	logic signed [BW-1:0] base_q;
	logic [SW-1:0]        sum_q;
	logic [SW-1:0]        prev_q;
	logic [WINDOW-1:0]    filled_q;

	// Ring memory
	logic [QW-1:0]        ring_mem [WINDOW];

	// Pipeline registers
	logic signed [daesm_pkg::SAMPLE_W-1:0] sample_s1;
	logic signed [BW-1:0]                  base_s1;
	logic [QW-1:0]                         sq_s2;
	logic [QW-1:0]                         old_s2;
	logic                                  old_vld_s2;
	logic [SW-1:0]                         sum_s3;
	logic [SW-1:0]                         sum_s4;
	logic [daesm_pkg::TOL_W-1:0]           tol_s4;

	// Baseline update at accept: base += trunc((scaled - base) / 200)
	logic signed [BW-1:0] scaled0, dev, dev_neg, step_mag, step, base_nxt;
	logic [BW-2:0]        dev_mag;
	logic [BW-5:0]        dev_div8;
	logic [50:0]          quo_prod;
	logic [20:0]          quo;

	assign scaled0  = {sample[daesm_pkg::SAMPLE_W-1], sample, {daesm_pkg::FRAC_W{1'b0}}};
	assign dev      = scaled0 - base_q;
	assign dev_neg  = -dev;
	assign dev_mag  = dev[BW-1] ? dev_neg[BW-2:0] : dev[BW-2:0];
	assign dev_div8 = dev_mag[BW-2:3];
	assign quo_prod = {26'b0, dev_div8} * {25'b0, daesm_pkg::RECIP_25};
	assign quo      = quo_prod[50:daesm_pkg::RECIP_25_SH];
	assign step_mag = {8'b0, quo};
	assign step     = dev[BW-1] ? -step_mag : step_mag;
	assign base_nxt = base_q + step;

	// s1: residual truncated toward zero, then squared
	logic signed [BW-1:0]                 scaled1, diff, rnd, adj;
	logic signed [daesm_pkg::WHOLE_W-1:0] whole;
	logic signed [2*daesm_pkg::WHOLE_W-1:0] sq_full;

	assign scaled1 = {sample_s1[daesm_pkg::SAMPLE_W-1], sample_s1,
		{daesm_pkg::FRAC_W{1'b0}}};
	assign diff    = scaled1 - base_s1;
	assign rnd     = {{(BW - daesm_pkg::FRAC_W){1'b0}}, {daesm_pkg::FRAC_W{diff[BW-1]}}};
	assign adj     = diff + rnd;
	assign whole   = adj[BW-1:daesm_pkg::FRAC_W];
	assign sq_full = $signed({{daesm_pkg::WHOLE_W{whole[daesm_pkg::WHOLE_W-1]}}, whole})
		* $signed({{daesm_pkg::WHOLE_W{whole[daesm_pkg::WHOLE_W-1]}}, whole});

	// s2: running sum, entry never written reads as zero
	logic [QW-1:0] old_eff;
	logic [SW-1:0] sum_nxt;

	assign old_eff = old_vld_s2 ? old_s2 : '0;
	assign sum_nxt = sum_q - {{(SW - QW){1'b0}}, old_eff} + {{(SW - QW){1'b0}}, sq_s2};

	// s3: tolerance = sum/10 + offset
	logic [2*SW-1:0]               tenth_prod;
	logic [daesm_pkg::TOL_W-1:0]   tol;

	assign tenth_prod = {{SW{1'b0}}, sum_s3} * {{SW{1'b0}}, daesm_pkg::RECIP_10};
	assign tol = {1'b0, tenth_prod[2*SW-1:daesm_pkg::RECIP_10_SH]}
		+ {{(daesm_pkg::TOL_W - daesm_pkg::OFFS_W){1'b0}}, tol_offset};

	// s4: steady when the sum moved less than the tolerance
	logic [SW-1:0] delta;

	assign delta  = (sum_s4 >= prev_q) ? (sum_s4 - prev_q) : (prev_q - sum_s4);
	assign steady = delta < {{(SW - daesm_pkg::TOL_W){1'b0}}, tol_s4};
	assign sum    = sum_s4;

	// State with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			sum_q      <= '0;
			prev_q     <= '0;
			filled_q   <= '0;
			old_vld_s2 <= 1'b0;
		end else begin
			if (ctl.take) begin
				base_q <= base_nxt;
			end
			if (ctl.adv2) begin
				old_vld_s2 <= filled_q[rd_addr];
			end
			if (ctl.adv3) begin
				sum_q             <= sum_nxt;
				filled_q[wr_addr] <= 1'b1;
			end
			if (ctl.adv_out) begin
				prev_q <= sum_s4;
			end
		end
	end

	// Ring memory: write from s2, registered read into s2
	always_ff @(posedge clk) begin
		if (ctl.adv3) begin
			ring_mem[wr_addr] <= sq_s2;
		end
		if (ctl.adv2) begin
			old_s2 <= ring_mem[rd_addr];
		end
	end

	// Payload pipeline
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			sample_s1 <= sample;
			base_s1   <= base_nxt;
		end
		if (ctl.adv2) begin
			sq_s2 <= sq_full[QW-1:0];
		end
		if (ctl.adv3) begin
			sum_s3 <= sum_nxt;
		end
		if (ctl.adv4) begin
			sum_s4 <= sum_s3;
			tol_s4 <= tol;
		end
	end

endmodule

// File: hdl/dual_ac_energy_stability_monitor.sv
`timescale 1ns / 1ps

// Dual-channel AC energy monitor with stability flag.
// samples: one beat carries a signed 12-bit pair (sample_a, sample_b).
// results: one beat per sample beat, in order: the windowed sums of squared
//   baseline-removed samples per channel, and stable, which is high once
//   both sums have been steady for stable_run_target pairs in a row.
// cfg: register writes (index 0 stable_run_target, 1 tolerance_offset),
//   always ready; write only while no sample is in flight.
// A result beat is offered after its sample beat has passed the stages in order
//   (baseline, square and ring read, sum and ring write, tolerance, compare).
// Throughput: one pair per cycle when unstalled; ring reads run one stage
//   ahead of writes, so the single read and write port serve an item each cycle.
// Reset clears baselines, sums, the run counter and the ring occupancy
//   flags; ring entries not yet written read as zero, so no clearing pass
//   is needed and samples can be taken as soon as reset is released.
// When the result receiver stalls, beats keep moving into empty stages;
//   samples.ready drops only when all five stages hold a beat.
module dual_ac_energy_stability_monitor #(
	parameter int WINDOW = daesm_pkg::WINDOW_DEF
) (
	input logic          clk,
	input logic          arst_n,
	daesm_smp_if.sink    samples,
	daesm_res_if.source  results,
	daesm_cfg_if.sink    cfg
);

	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	// Configuration registers
	logic [daesm_pkg::RUN_W-1:0]  target_q;
	logic [daesm_pkg::OFFS_W-1:0] offset_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= daesm_pkg::RUN_TARGET_RST;
			offset_q <= daesm_pkg::TOL_OFFSET_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				daesm_pkg::CFG_RUN_TARGET: target_q <= cfg.data[daesm_pkg::RUN_W-1:0];
				daesm_pkg::CFG_TOL_OFFSET: offset_q <= cfg.data[daesm_pkg::OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline occupancy and advance
	logic v_s1, v_s2, v_s3, v_s4, out_v_q;
	daesm_pkg::daesm_ctl_t ctl;

	assign ctl.adv_out = v_s4 && (!out_v_q || results.ready);
	assign ctl.adv4    = v_s3 && (!v_s4 || ctl.adv_out);
	assign ctl.adv3    = v_s2 && (!v_s3 || ctl.adv4);
	assign ctl.adv2    = v_s1 && (!v_s2 || ctl.adv3);
	assign samples.ready = !v_s1 || ctl.adv2;
	assign ctl.take    = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ctl.take || ctl.adv2)    v_s1    <= ctl.take;
			if (ctl.adv2 || ctl.adv3)    v_s2    <= ctl.adv2;
			if (ctl.adv3 || ctl.adv4)    v_s3    <= ctl.adv3;
			if (ctl.adv4 || ctl.adv_out) v_s4    <= ctl.adv4;
			if (ctl.adv_out || results.ready) out_v_q <= ctl.adv_out;
		end
	end

	// Shared ring position
	logic [AW-1:0] pos_q, pos_s1, pos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctl.take) begin
			pos_q <= (pos_q == AW'(WINDOW - 1)) ? '0 : pos_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) pos_s1 <= pos_q;
		if (ctl.adv2) pos_s2 <= pos_s1;
	end

	// Channel datapaths
	logic [daesm_pkg::SUM_W-1:0] sum_a, sum_b;
	logic                        steady_a, steady_b;

	daesm_chan #(.WINDOW(WINDOW)) u_chan_a (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sample     (samples.sample_a),
		.rd_addr    (pos_s1),
		.wr_addr    (pos_s2),
		.tol_offset (offset_q),
		.sum        (sum_a),
		.steady     (steady_a)
	);

	daesm_chan #(.WINDOW(WINDOW)) u_chan_b (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sample     (samples.sample_b),
		.rd_addr    (pos_s1),
		.wr_addr    (pos_s2),
		.tol_offset (offset_q),
		.sum        (sum_b),
		.steady     (steady_b)
	);

	// Steady run counter, saturating at the target
	logic [daesm_pkg::RUN_W-1:0] run_q, run_nxt;

	always_comb begin
		if (steady_a && steady_b) begin
			run_nxt = (run_q < target_q) ? run_q + daesm_pkg::RUN_W'(1) : run_q;
		end else begin
			run_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (ctl.adv_out) begin
			run_q <= run_nxt;
		end
	end

	// Output register
	logic [daesm_pkg::SUM_W-1:0] energy_a_q, energy_b_q;
	logic                        stable_q;

	always_ff @(posedge clk) begin
		if (ctl.adv_out) begin
			energy_a_q <= sum_a;
			energy_b_q <= sum_b;
			stable_q   <= run_nxt >= target_q;
		end
	end

	assign results.valid    = out_v_q;
	assign results.energy_a = energy_a_q;
	assign results.energy_b = energy_b_q;
	assign results.stable   = stable_q;

	// Ring position stays inside the window
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) < WINDOW)
		else $error("ring position out of window");

	// Ring read and write in one cycle never touch the same entry
	a_ring_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.adv2 && ctl.adv3) |-> (pos_s1 != pos_s2))
		else $error("ring read and write collide");

	// Run counter only clears, holds or steps by one
	a_run_step: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q != $past(run_q)) |->
			(run_q == '0 || run_q == $past(run_q) + daesm_pkg::RUN_W'(1)))
		else $error("run counter jumped");

endmodule

// File: tb/dual_ac_energy_stability_monitor_test.sv
`timescale 1ns / 1ps

// One expected result beat
typedef struct {
	logic [daesm_pkg::SUM_W-1:0] energy_a;
	logic [daesm_pkg::SUM_W-1:0] energy_b;
	logic                        stable;
} energy_result_t;

// Energy/stability predictor and in-order result checker
class energy_scoreboard;
	localparam int     DEPTH    = daesm_pkg::WINDOW_DEF;
	localparam longint FRAC_ONE = longint'(1) << daesm_pkg::FRAC_W;
	localparam longint BASE_DIV = 200;
	localparam int     TOL_DIV  = 10;

	logic [daesm_pkg::RUN_W-1:0]  run_target;
	logic [daesm_pkg::OFFS_W-1:0] tol_offset;
	longint                       baseline [2];
	logic [daesm_pkg::SQ_W-1:0]   squares [2][DEPTH];
	logic [daesm_pkg::SUM_W-1:0]  win_sum [2];
	logic [daesm_pkg::SUM_W-1:0]  last_sum [2];
	int unsigned                  ring_pos;
	logic [daesm_pkg::RUN_W-1:0]  steady_run;
	energy_result_t               expected_q [$];
	int                           errors;

	function void clear();
		run_target = daesm_pkg::RUN_TARGET_RST;
		tol_offset = daesm_pkg::TOL_OFFSET_RST;
		for (int ch = 0; ch < 2; ch++) begin
			baseline[ch] = 0;
			win_sum[ch] = '0;
			last_sum[ch] = '0;
			for (int i = 0; i < DEPTH; i++)
				squares[ch][i] = '0;
		end
		ring_pos = 0;
		steady_run = '0;
		expected_q.delete();
		errors = 0;
	endfunction

	function void write_reg(logic [daesm_pkg::CFG_IDX_W-1:0] idx,
			logic [daesm_pkg::CFG_DATA_W-1:0] data);
		case (idx)
		daesm_pkg::CFG_RUN_TARGET: run_target = data[daesm_pkg::RUN_W-1:0];
		daesm_pkg::CFG_TOL_OFFSET: tol_offset = data[daesm_pkg::OFFS_W-1:0];
		default: ;
		endcase
	endfunction

	// Baseline update, squared residual, ring and windowed sum for one channel
	function logic [daesm_pkg::SUM_W-1:0] fold_sample(int ch,
			logic signed [daesm_pkg::SAMPLE_W-1:0] smp, int unsigned pos);
		longint                     scaled;
		longint                     whole;
		logic [daesm_pkg::SQ_W-1:0] sq;
		scaled = longint'(smp) * FRAC_ONE;
		// integer division truncates toward zero, as the hardware does
		baseline[ch] += (scaled - baseline[ch]) / BASE_DIV;
		whole = (scaled - baseline[ch]) / FRAC_ONE;
		sq = daesm_pkg::SQ_W'(whole * whole);
		win_sum[ch] = win_sum[ch] - squares[ch][pos] + sq;
		squares[ch][pos] = sq;
		return win_sum[ch];
	endfunction

	// Sum moved less than sum/10 plus offset since the previous pair
	function bit channel_steady(int ch);
		logic [daesm_pkg::SUM_W-1:0] delta;
		int unsigned                 tol;
		delta = (win_sum[ch] >= last_sum[ch]) ? win_sum[ch] - last_sum[ch]
			: last_sum[ch] - win_sum[ch];
		tol = win_sum[ch] / TOL_DIV + tol_offset;
		last_sum[ch] = win_sum[ch];
		return delta < tol;
	endfunction

	function void take_pair(logic signed [daesm_pkg::SAMPLE_W-1:0] a,
			logic signed [daesm_pkg::SAMPLE_W-1:0] b);
		int unsigned    pos;
		energy_result_t r;
		bit             steady_a;
		bit             steady_b;
		pos = (ring_pos >= DEPTH) ? 0 : ring_pos;
		r.energy_a = fold_sample(0, a, pos);
		r.energy_b = fold_sample(1, b, pos);
		pos++;
		if (pos >= DEPTH)
			pos = 0;
		ring_pos = pos;
		steady_a = channel_steady(0);
		steady_b = channel_steady(1);
		// run counter saturates at the target, clears on any unsteady pair
		if (steady_a && steady_b) begin
			if (steady_run < run_target)
				steady_run++;
		end else begin
			steady_run = '0;
		end
		r.stable = (steady_run >= run_target);
		expected_q.push_back(r);
	endfunction

	function void check_result(logic [daesm_pkg::SUM_W-1:0] ea,
			logic [daesm_pkg::SUM_W-1:0] eb, logic st);
		energy_result_t want;
		if (expected_q.size() == 0) begin
			$error("result beat with no pair pending: energy_a=%0d energy_b=%0d stable=%0d",
				ea, eb, st);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		if (ea !== want.energy_a) begin
			$error("energy_a expected %0d actual %0d", want.energy_a, ea);
			errors++;
		end
		if (eb !== want.energy_b) begin
			$error("energy_b expected %0d actual %0d", want.energy_b, eb);
			errors++;
		end
		if (st !== want.stable) begin
			$error("stable expected %0d actual %0d", want.stable, st);
			errors++;
		end
	endfunction
endclass

module dual_ac_energy_stability_monitor_test;

	localparam int SAMPLE_MAX      = 2047;
	localparam int SAMPLE_MIN      = -2048;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int SETTLE_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RESET_CYCLES    = 9;
	localparam int PHASE_ITEMS     = 190;

	// Directed pairs: field extremes, sign boundaries, alternating bit patterns
	localparam int EDGE_A [12] = '{0, 2047, -2048, 2047, -2048, -1, 1, 1365, -1366, 0, -1, 2047};
	localparam int EDGE_B [12] = '{0, -2048, 2047, 2047, -2048, 1, -1, -1366, 1365, -1, 0, -2048};

	logic clk;
	logic arst_n;

	daesm_smp_if samples ();
	daesm_res_if results ();
	daesm_cfg_if cfg ();

	energy_scoreboard energy_sb;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	bit hold_go;
	int quiet_cycles;
	bit beat_seen;

	dual_ac_energy_stability_monitor u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.results(results),
		.cfg    (cfg)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Result receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			results.ready <= 1'b0;
		end else begin
			results.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Beat monitor, scoreboard hookup and watchdog
	always @(posedge clk) begin
		beat_seen = 1'b0;
		if (cfg.valid && cfg.ready) begin
			energy_sb.write_reg(cfg.index, cfg.data);
			beat_seen = 1'b1;
		end
		if (samples.valid && samples.ready) begin
			energy_sb.take_pair(samples.sample_a, samples.sample_b);
			beat_seen = 1'b1;
		end
		if (results.valid && results.ready) begin
			energy_sb.check_result(results.energy_a, results.energy_b, results.stable);
			beat_seen = 1'b1;
		end
		if (beat_seen)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("dual_ac_energy_stability_monitor verification failed");
			$finish;
		end
	end

	function automatic logic signed [daesm_pkg::SAMPLE_W-1:0] to_sample(int v);
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		if (v < SAMPLE_MIN)
			v = SAMPLE_MIN;
		return v[daesm_pkg::SAMPLE_W-1:0];
	endfunction

	// Offer one pair, hold until taken, then maybe go idle for a while
	task automatic send_pair(input logic signed [daesm_pkg::SAMPLE_W-1:0] a,
			input logic signed [daesm_pkg::SAMPLE_W-1:0] b);
		samples.valid <= 1'b1;
		samples.sample_a <= a;
		samples.sample_b <= b;
		do @(posedge clk); while (!samples.ready);
		if ($urandom_range(99) < send_idle_pct) begin
			samples.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Wait for every expected beat, then let the pipeline settle
	task automatic drain();
		samples.valid <= 1'b0;
		while (energy_sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both registers, back to back with valid held high
	task automatic program_regs(input int target, input int offset);
		cfg.valid <= 1'b1;
		cfg.index <= daesm_pkg::CFG_RUN_TARGET;
		cfg.data <= target[daesm_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg.ready);
		cfg.index <= daesm_pkg::CFG_TOL_OFFSET;
		cfg.data <= offset[daesm_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_quiet(input int count);
		repeat (count) send_pair('0, '0);
	endtask

	// Random segments: mostly bounded AC around a DC level, some full-scale
	// noise, flat DC runs and rail-to-rail bursts that break steadiness
	task automatic send_segments(input int count);
		int kind;
		int seg_len;
		int dc_a;
		int dc_b;
		int amp_a;
		int amp_b;
		int v_a;
		int v_b;
		int sent;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(99);
			seg_len = $urandom_range(100, 8);
			dc_a = int'($urandom_range(4095)) + SAMPLE_MIN;
			dc_b = int'($urandom_range(4095)) + SAMPLE_MIN;
			amp_a = $urandom_range(SAMPLE_MAX);
			amp_b = $urandom_range(SAMPLE_MAX);
			repeat (seg_len) begin
				if (sent >= count)
					break;
				if (kind < 55) begin
					v_a = dc_a + int'($urandom_range(2 * amp_a)) - amp_a;
					v_b = dc_b + int'($urandom_range(2 * amp_b)) - amp_b;
				end else if (kind < 75) begin
					v_a = int'($urandom_range(4095)) + SAMPLE_MIN;
					v_b = int'($urandom_range(4095)) + SAMPLE_MIN;
				end else if (kind < 90) begin
					v_a = dc_a;
					v_b = dc_b;
				end else begin
					v_a = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
					v_b = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
				end
				send_pair(to_sample(v_a), to_sample(v_b));
				sent++;
			end
		end
	endtask

	task automatic run_phase(input int target, input int offset, input int idle_pct,
			input int stall_pct, input bit hold_off);
		program_regs(target, offset);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		if (hold_off)
			hold_go = 1'b1;
		send_segments(PHASE_ITEMS);
		drain();
	endtask

	initial begin
		energy_sb = new;
		energy_sb.clear();
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.sample_a = '0;
		samples.sample_b = '0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = daesm_pkg::CFG_RUN_TARGET;
		cfg.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		hold_go = 1'b0;
		quiet_cycles = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed extremes at the reset register values
		for (int i = 0; i < 12; i++)
			send_pair(to_sample(EDGE_A[i]), to_sample(EDGE_B[i]));
		for (int i = 0; i < 12; i++)
			send_pair(to_sample(i % 2 ? SAMPLE_MAX : SAMPLE_MIN),
				to_sample(i % 2 ? SAMPLE_MIN : SAMPLE_MAX));
		drain();

		// Quiet input past a full ring: run count climbs to the target
		program_regs(40, 255);
		send_quiet(130);
		drain();

		// Target lowered under the count: count holds, stable stays up
		program_regs(10, 255);
		send_quiet(20);
		drain();

		// Target of zero: stable always set, count never steps up
		program_regs(0, 0);
		send_segments(40);
		drain();

		// Random phases across idling modes and register settings
		run_phase(1023, 0, 0, 0, 1'b1);
		run_phase(1, 255, 54, 0, 1'b0);
		run_phase(int'(daesm_pkg::RUN_TARGET_RST), int'(daesm_pkg::TOL_OFFSET_RST),
			0, 54, 1'b0);
		run_phase($urandom_range(80, 2), $urandom_range(255), 30, 30, 1'b0);

		if (energy_sb.errors == 0)
			$display("dual_ac_energy_stability_monitor verification clean");
		else
			$display("dual_ac_energy_stability_monitor verification failed");
		$finish;
	end

endmodule
